/* src/oaht_pkg.sv */
`default_nettype none
package oaht_pkg;

   localparam int CAPACITY   = 256;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 64;
   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int COUNT_BITS = IDX_BITS + 1;
   localparam int LIMIT_BITS = 8;
   localparam logic [LIMIT_BITS-1:0] LOAD_LIMIT_RESET = 8'd192;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_FIND   = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY = 2'd0,
      SLOT_USED  = 2'd1,
      SLOT_TOMB  = 2'd2,
      SLOT_BAD   = 2'd3
   } slot_state_type;

   typedef enum logic [1:0] {
      RES_OK     = 2'd0,
      RES_ABSENT = 2'd1,
      RES_FULL   = 2'd2,
      RES_RSVD   = 2'd3
   } result_type;

   typedef struct packed {
      slot_state_type        state;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef struct packed {
      logic                we;
      logic                set_valid;
      logic [IDX_BITS-1:0] addr;
      entry_type           wdata;
   } mem_req_type;

endpackage
`default_nettype wire

/* src/oaht_ram.sv */
`default_nettype none
module oaht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

/* src/oaht_ctrl.sv */
`default_nettype none
module oaht_ctrl import oaht_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [1:0]            req_action,
   input  wire logic [31:0]           req_key_id,
   input  wire logic [31:0]           req_key_hash,
   input  wire logic [63:0]           req_value_in,
   input  wire logic [LIMIT_BITS-1:0] load_limit,
   output mem_req_type                mem_req,
   input  wire entry_type             mem_rdata,
   input  wire logic                  mem_valid,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_was_new,
   output logic [63:0]                rsp_value_out
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   action_type            action_ff, action_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic [IDX_BITS-1:0]   cnt_ff, cnt_in;
   logic                  have_tomb_ff, have_tomb_in;
   logic [IDX_BITS-1:0]   tomb_ff, tomb_in;
   logic                  hit_ff, hit_in;
   logic                  found_ff, found_in;
   logic                  slot_empty_ff, slot_empty_in;
   logic [IDX_BITS-1:0]   slot_ff, slot_in;
   logic [VALUE_BITS-1:0] hit_value_ff, hit_value_in;
   logic [COUNT_BITS-1:0] used_ff, used_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            status_ff, status_in;
   logic                  was_new_ff, was_new_in;
   logic [63:0]           vout_ff, vout_in;

   slot_state_type        probe_state;
   logic                  key_match;

   always_comb begin
      probe_state = mem_valid ? mem_rdata.state : SLOT_EMPTY;
      key_match   = (probe_state == SLOT_USED) && (mem_rdata.key == key_ff);
   end

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      have_tomb_in  = have_tomb_ff;
      tomb_in       = tomb_ff;
      hit_in        = hit_ff;
      found_in      = found_ff;
      slot_empty_in = slot_empty_ff;
      slot_in       = slot_ff;
      hit_value_in  = hit_value_ff;
      used_in       = used_ff;
      rsp_valid_in  = 1'b0;
      status_in     = status_ff;
      was_new_in    = was_new_ff;
      vout_in       = vout_ff;

      mem_req           = '0;
      mem_req.addr      = idx_ff + IDX_BITS'(1);
      mem_req.wdata     = '{state: SLOT_USED, key: key_ff, value: value_ff};

      unique case (state_ff)
         ST_IDLE: begin
            mem_req.addr = req_key_hash[IDX_BITS-1:0];
            if (start) begin
               action_in    = action_type'(req_action);
               key_in       = req_key_id[KEY_BITS-1:0];
               value_in     = req_value_in[VALUE_BITS-1:0];
               idx_in       = req_key_hash[IDX_BITS-1:0];
               cnt_in       = '0;
               have_tomb_in = 1'b0;
               hit_in       = 1'b0;
               found_in     = 1'b0;
               // skip the probe for unknown actions and lookups in an empty table
               if ((action_type'(req_action) == ACT_NONE) ||
                   ((action_type'(req_action) != ACT_INSERT) && (used_ff == '0))) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            if (key_match) begin
               hit_in       = 1'b1;
               found_in     = 1'b1;
               slot_in      = idx_ff;
               hit_value_in = mem_rdata.value;
               state_in     = ST_FINISH;
            end else if (probe_state == SLOT_EMPTY) begin
               found_in      = 1'b1;
               slot_in       = have_tomb_ff ? tomb_ff : idx_ff;
               slot_empty_in = !have_tomb_ff;
               state_in      = ST_FINISH;
            end else if (cnt_ff == '1) begin
               // wrapped all the way round: only a tombstone can take an insert
               found_in      = have_tomb_ff || (probe_state == SLOT_TOMB);
               slot_in       = have_tomb_ff ? tomb_ff : idx_ff;
               slot_empty_in = 1'b0;
               state_in      = ST_FINISH;
            end else begin
               idx_in = idx_ff + IDX_BITS'(1);
               cnt_in = cnt_ff + IDX_BITS'(1);
               if ((probe_state == SLOT_TOMB) && !have_tomb_ff) begin
                  have_tomb_in = 1'b1;
                  tomb_in      = idx_ff;
               end
            end
         end
         ST_FINISH: begin
            mem_req.addr = slot_ff;
            status_in    = RES_ABSENT;
            was_new_in   = 1'b0;
            vout_in      = '0;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            case (action_ff)
               ACT_INSERT: begin
                  if (!found_ff) begin
                     status_in = RES_FULL;
                  end else if (hit_ff) begin
                     mem_req.we = 1'b1;
                     status_in  = RES_OK;
                  end else if (!slot_empty_ff) begin
                     mem_req.we = 1'b1;
                     status_in  = RES_OK;
                     was_new_in = 1'b1;
                  end else if (used_ff >= {1'b0, load_limit}) begin
                     status_in = RES_FULL;
                  end else begin
                     mem_req.we        = 1'b1;
                     mem_req.set_valid = 1'b1;
                     used_in           = used_ff + COUNT_BITS'(1);
                     status_in         = RES_OK;
                     was_new_in        = 1'b1;
                  end
               end
               ACT_FIND: begin
                  if (hit_ff) begin
                     status_in = RES_OK;
                     vout_in   = 64'(hit_value_ff);
                  end
               end
               ACT_REMOVE: begin
                  if (hit_ff) begin
                     mem_req.we          = 1'b1;
                     mem_req.wdata.state = SLOT_TOMB;
                     status_in           = RES_OK;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff     <= action_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      have_tomb_ff  <= have_tomb_in;
      tomb_ff       <= tomb_in;
      hit_ff        <= hit_in;
      found_ff      <= found_in;
      slot_empty_ff <= slot_empty_in;
      slot_ff       <= slot_in;
      hit_value_ff  <= hit_value_in;
      status_ff     <= status_in;
      was_new_ff    <= was_new_in;
      vout_ff       <= vout_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_was_new   = was_new_ff;
   assign rsp_value_out = vout_ff;

endmodule
`default_nettype wire

/* src/open_addressing_hash_table_unit.sv */
`default_nettype none
// Key-value table with linear probing and tombstones, CAPACITY slots.
// Request channel: drive req_action (insert, find, remove), req_key_id,
// req_key_hash and req_value_in with start; the request is taken at a clock
// edge where start is high and busy is low. busy stays high until the request
// has been resolved.
// Response channel: rsp_valid is high for exactly one cycle with rsp_status,
// rsp_was_new and rsp_value_out. The receiver cannot stall; a response is
// never repeated.
// Sequence: the request is accepted, then the slots are probed in turn
// (the single RAM read port reads one slot per cycle), then the finish
// step updates the slot; the response shows in the cycle after that. busy
// stays high through the probes and the finish step; lookups on an empty
// table and unknown actions skip the probes and go straight to finish.
// A new request may start in the cycle the previous response is shown.
// csr_write_enable writes the load limit (reset 192); write only while idle.
// Reset (synchronous) empties the table at once through per-slot valid bits
// and clears the fill count; no clearing pass is needed.
module open_addressing_hash_table_unit import oaht_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [31:0] req_key_id,
   input  wire logic [31:0] req_key_hash,
   input  wire logic [63:0] req_value_in,
   input  wire logic        csr_write_enable,
   input  wire logic [7:0]  csr_write_data,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic             rsp_was_new,
   output logic [63:0]      rsp_value_out
);

   logic [LIMIT_BITS-1:0] load_limit_ff;
   logic [CAPACITY-1:0]   slot_valid_ff;
   logic                  rd_valid_ff;
   mem_req_type           mem_req;
   logic [ENTRY_BITS-1:0] mem_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_limit_ff <= LOAD_LIMIT_RESET;
         slot_valid_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            load_limit_ff <= csr_write_data[LIMIT_BITS-1:0];
         end
         if (mem_req.we && mem_req.set_valid) begin
            slot_valid_ff[mem_req.addr] <= 1'b1;
         end
      end
      // track the RAM's registered read so a never-written slot reads empty
      rd_valid_ff <= slot_valid_ff[mem_req.addr];
   end

   oaht_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock (clock),
      .we    (mem_req.we),
      .addr  (mem_req.addr),
      .wdata (mem_req.wdata),
      .rdata (mem_rdata)
   );

   oaht_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_action    (req_action),
      .req_key_id    (req_key_id),
      .req_key_hash  (req_key_hash),
      .req_value_in  (req_value_in),
      .load_limit    (load_limit_ff),
      .mem_req       (mem_req),
      .mem_rdata     (entry_type'(mem_rdata)),
      .mem_valid     (rd_valid_ff),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_was_new   (rsp_was_new),
      .rsp_value_out (rsp_value_out)
   );

endmodule
`default_nettype wire
